>>> sv/w2r_pkg.sv
package w2r_pkg;

  // World coordinate width (Q24.8 at the default of 32 bits).
  localparam int COORD_WIDTH = 32;

  // Position difference, saturated to +-(2^44 - 1).
  localparam int DIFF_WIDTH = (COORD_WIDTH + 1 < 45) ? COORD_WIDTH + 1 : 45;
  localparam int SAT_WIDTH  = (COORD_WIDTH + 1 > 46) ? COORD_WIDTH + 1 : 46;
  localparam longint DIFF_SAT_MAX = (64'sd1 <<< 44) - 64'sd1;

  // Sine and cosine: Q16, quarter wave over a 14-bit angle fraction.
  localparam int ANGLE_WIDTH = 16;
  localparam int ANG_FRAC    = 14;
  localparam int ARG_WIDTH   = ANG_FRAC + 1;
  localparam int QUARTER     = 1 << ANG_FRAC;
  localparam int TRIG_WIDTH  = 18;
  localparam int SIN_ONE     = 65536;
  localparam int SIN_A       = 102944;
  localparam int SIN_B       = 42048;
  localparam int SIN_C       = 4640;

  // Rotated offset, Q24 world units.
  localparam int PROD_WIDTH  = DIFF_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;
  localparam int POS_FRAC    = 24;
  localparam int SHIFT_WIDTH = SUM_WIDTH - POS_FRAC;

  // Screen placement.
  localparam int CFG_WIDTH     = 12;
  localparam int PIX_WIDTH     = 13;
  localparam int CENTER_WIDTH  = CFG_WIDTH + 2;
  localparam int DOT_SIZE      = 18;
  localparam int SCALE_DIV     = 150;
  localparam int CENTER_MUL    = SCALE_DIV / 2;
  localparam int DIV_IN_WIDTH  = 21;
  localparam int DIV_LIMIT     = SCALE_DIV << PIX_WIDTH;
  localparam int MID_WIDTH     = ((SHIFT_WIDTH > DIV_IN_WIDTH) ? SHIFT_WIDTH : DIV_IN_WIDTH) + 2;
  localparam int RECIP_SHIFT   = 29;
  localparam int RECIP_WIDTH   = 22;
  localparam longint RECIP     = ((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] viewer_x;
    logic signed [COORD_WIDTH-1:0] viewer_y;
    logic [ANGLE_WIDTH-1:0]        view_yaw;
  } in_item_t;

  typedef struct packed {
    logic [PIX_WIDTH-1:0] dot_x;
    logic [PIX_WIDTH-1:0] dot_y;
  } out_item_t;

endpackage

>>> sv/w2r_sin.sv
module w2r_sin
  import w2r_pkg::*;
(
  input  logic                         clk,
  input  logic [3:0]                   en,
  input  logic [ARG_WIDTH-1:0]         angle,
  input  logic                         negate,
  output logic signed [TRIG_WIDTH-1:0] value
);

  logic [ARG_WIDTH-1:0] x2_a, x2_b;
  logic [ARG_WIDTH-1:0] r_a, r_b, r_c;
  logic                 neg_a, neg_b, neg_c;
  logic [12:0]          t1_b;
  logic [15:0]          t2_c;

  logic [2*ARG_WIDTH-1:0] sq_prod;
  logic [27:0]            t1_prod;
  logic [15:0]            t2_diff;
  logic [30:0]            t2_prod;
  logic [16:0]            t3_diff;
  logic [31:0]            t3_prod;
  logic [17:0]            t3;
  logic [16:0]            mag;

  always_comb begin
    sq_prod = angle * angle;
    t1_prod = 28'(x2_a) * 28'(SIN_C);
    t2_diff = 16'(SIN_B) - 16'(t1_b);
    t2_prod = 31'(t2_diff) * 31'(x2_b);
    t3_diff = 17'(SIN_A) - 17'(t2_c);
    t3_prod = 32'(t3_diff) * 32'(r_c);
    t3      = t3_prod[31:ANG_FRAC];
    // cap at 1.0
    mag     = (t3 > 18'(SIN_ONE)) ? 17'(SIN_ONE) : t3[16:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x2_a  <= sq_prod[ANG_FRAC+ARG_WIDTH-1:ANG_FRAC];
      r_a   <= angle;
      neg_a <= negate;
    end
    if (en[1]) begin
      t1_b  <= t1_prod[ANG_FRAC+12:ANG_FRAC];
      x2_b  <= x2_a;
      r_b   <= r_a;
      neg_b <= neg_a;
    end
    if (en[2]) begin
      t2_c  <= t2_prod[ANG_FRAC+15:ANG_FRAC];
      r_c   <= r_b;
      neg_c <= neg_b;
    end
    if (en[3]) begin
      value <= neg_c ? -$signed(TRIG_WIDTH'(mag)) : $signed(TRIG_WIDTH'(mag));
    end
  end

endmodule

>>> sv/w2r_place.sv
module w2r_place
  import w2r_pkg::*;
(
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic signed [SUM_WIDTH-1:0] pos,
  input  logic [CFG_WIDTH-1:0]        origin,
  input  logic [CFG_WIDTH-1:0]        size,
  output logic [PIX_WIDTH-1:0]        dot
);

  logic signed [SHIFT_WIDTH-1:0]  shifted;
  logic [CENTER_WIDTH-1:0]        center;
  logic [DIV_IN_WIDTH-1:0]        offset;
  logic signed [MID_WIDTH-1:0]    mid;
  logic [CENTER_WIDTH-1:0]        edge_sum;
  logic [PIX_WIDTH-1:0]           hi;
  logic [DIV_IN_WIDTH+RECIP_WIDTH-1:0] quot_prod;
  logic [PIX_WIDTH-1:0]           lo;
  logic [PIX_WIDTH-1:0]           low_pick;

  logic [DIV_IN_WIDTH-1:0] num_a;
  logic                    neg_a, big_a, neg_b, big_b;
  logic [PIX_WIDTH-1:0]    quot_b, hi_b;

  always_comb begin
    shifted   = pos[SUM_WIDTH-1:POS_FRAC];
    center    = CENTER_WIDTH'({origin, 1'b0}) + CENTER_WIDTH'(size) + CENTER_WIDTH'(1);
    offset    = DIV_IN_WIDTH'(center) * DIV_IN_WIDTH'(CENTER_MUL);
    mid       = MID_WIDTH'(shifted) + MID_WIDTH'(offset);
    quot_prod = (DIV_IN_WIDTH+RECIP_WIDTH)'(num_a) * (DIV_IN_WIDTH+RECIP_WIDTH)'(RECIP);
    edge_sum  = CENTER_WIDTH'(origin) + CENTER_WIDTH'(size);
    // upper bound never drops below zero
    hi        = (edge_sum < CENTER_WIDTH'(DOT_SIZE)) ? '0
                                                     : PIX_WIDTH'(edge_sum - CENTER_WIDTH'(DOT_SIZE));
    lo        = PIX_WIDTH'(origin);
    low_pick  = (lo > hi_b) ? hi_b : lo;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // divide only the range that can survive the clamp
      num_a <= mid[DIV_IN_WIDTH-1:0];
      neg_a <= mid[MID_WIDTH-1];
      big_a <= !mid[MID_WIDTH-1] && (mid >= MID_WIDTH'(DIV_LIMIT));
    end
    if (en[1]) begin
      quot_b <= quot_prod[RECIP_SHIFT+PIX_WIDTH-1:RECIP_SHIFT];
      neg_b  <= neg_a;
      big_b  <= big_a;
      hi_b   <= hi;
    end
    if (en[2]) begin
      if (big_b) begin
        dot <= hi_b;
      end else if (neg_b || quot_b < lo) begin
        dot <= low_pick;
      end else if (quot_b > hi_b) begin
        dot <= hi_b;
      end else begin
        dot <= quot_b;
      end
    end
  end

endmodule

>>> sv/world_to_radar_dot.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    in_item  (target, viewer, yaw)
// out       out  out_valid / out_stall  out_item (dot_x, dot_y)
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data (12-bit window regs)
//
// One request per cycle while in_stall is low; a result passes ten register stages
// to out. The depth is set by the input difference and yaw fold, the four
// dependent multiplies of the sine polynomial, then the rotation multiply, the
// offset sum and a three-stage divide and clamp.
// rst clears all stage valid bits and loads the window registers (0, 0, 256, 256).
// out_stall holds the output register; empty stages further up keep filling,
// and in_stall rises only when every stage is full behind a stalled output.
module world_to_radar_dot
  import w2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int STAGES = 10;

  function automatic logic signed [DIFF_WIDTH-1:0] sat_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [SAT_WIDTH-1:0] raw;
    logic signed [SAT_WIDTH-1:0] lim;
    raw = SAT_WIDTH'(a) - SAT_WIDTH'(b);
    lim = SAT_WIDTH'(DIFF_SAT_MAX);
    if (raw > lim) begin
      raw = lim;
    end else if (raw < -lim) begin
      raw = -lim;
    end
    return DIFF_WIDTH'(raw);
  endfunction

  logic [CFG_WIDTH-1:0] radar_left, radar_top, radar_width, radar_height;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  logic [1:0]           quad_s, quad_c;
  logic [ANG_FRAC-1:0]  frac;

  logic [ARG_WIDTH-1:0]         ang_s, ang_c;
  logic                         neg_s, neg_c;
  logic signed [DIFF_WIDTH-1:0] d1_p [5];
  logic signed [DIFF_WIDTH-1:0] d2_p [5];
  logic signed [TRIG_WIDTH-1:0] sin_v, cos_v;
  logic signed [PROD_WIDTH-1:0] pc1, ps2, pc2, ps1;
  logic signed [SUM_WIDTH-1:0]  pos_x, pos_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radar_left   <= '0;
      radar_top    <= '0;
      radar_width  <= CFG_WIDTH'(256);
      radar_height <= CFG_WIDTH'(256);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEFT:   radar_left   <= cfg_data;
        REG_TOP:    radar_top    <= cfg_data;
        REG_WIDTH:  radar_width  <= cfg_data;
        REG_HEIGHT: radar_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Fold the yaw onto a quarter wave; cosine is the sine a quarter turn on.
  always_comb begin
    quad_s = in_item.view_yaw[ANGLE_WIDTH-1:ANG_FRAC];
    quad_c = quad_s + 2'd1;
    frac   = in_item.view_yaw[ANG_FRAC-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_p[0] <= sat_diff(in_item.target_y, in_item.viewer_y);
      d2_p[0] <= sat_diff(in_item.target_x, in_item.viewer_x);
      ang_s   <= quad_s[0] ? ARG_WIDTH'(QUARTER) - ARG_WIDTH'(frac) : ARG_WIDTH'(frac);
      ang_c   <= quad_c[0] ? ARG_WIDTH'(QUARTER) - ARG_WIDTH'(frac) : ARG_WIDTH'(frac);
      neg_s   <= quad_s[1];
      neg_c   <= quad_c[1];
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        d1_p[k] <= d1_p[k-1];
        d2_p[k] <= d2_p[k-1];
      end
    end
    if (en[5]) begin
      pc1 <= PROD_WIDTH'(d1_p[4]) * PROD_WIDTH'(cos_v);
      ps2 <= PROD_WIDTH'(d2_p[4]) * PROD_WIDTH'(sin_v);
      pc2 <= PROD_WIDTH'(d2_p[4]) * PROD_WIDTH'(cos_v);
      ps1 <= PROD_WIDTH'(d1_p[4]) * PROD_WIDTH'(sin_v);
    end
    if (en[6]) begin
      pos_x <= SUM_WIDTH'(pc1) - SUM_WIDTH'(ps2);
      // screen y runs opposite to the second axis
      pos_y <= -SUM_WIDTH'(pc2) - SUM_WIDTH'(ps1);
    end
  end

  w2r_sin u_sin (
    .clk    (clk),
    .en     (en[4:1]),
    .angle  (ang_s),
    .negate (neg_s),
    .value  (sin_v)
  );

  w2r_sin u_cos (
    .clk    (clk),
    .en     (en[4:1]),
    .angle  (ang_c),
    .negate (neg_c),
    .value  (cos_v)
  );

  w2r_place u_place_x (
    .clk    (clk),
    .en     (en[9:7]),
    .pos    (pos_x),
    .origin (radar_left),
    .size   (radar_width),
    .dot    (out_item.dot_x)
  );

  w2r_place u_place_y (
    .clk    (clk),
    .en     (en[9:7]),
    .pos    (pos_y),
    .origin (radar_top),
    .size   (radar_height),
    .dot    (out_item.dot_y)
  );

endmodule
